@@ hdl/lkvc_pkg.sv @@
package lkvc_pkg;

   localparam int DEFAULT_CAPACITY = 4;
   localparam int KEY_W = 32;
   localparam int VALUE_W = 32;

   // Request opcodes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // Value returned by a get that misses.
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // a request word is accepted this cycle
      logic scan;    // read the next entry out of the key and value stores
      logic commit;  // apply the update and load the result register
   } lkvc_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic scan_last;  // the entry being read is the last one
      logic out_free;   // the result register can take a new word
   } lkvc_status_type;

endpackage

@@ hdl/lkvc_if.sv @@
interface lkvc_req_if;
   import lkvc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [KEY_W-1:0]   lookup_key;
   logic signed [VALUE_W-1:0] write_value;

   modport source (output valid, output opcode, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_key, input write_value,
                   output ready);
endinterface

interface lkvc_rsp_if;
   import lkvc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;
   logic                      evicted;
   logic signed [KEY_W-1:0]   evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

@@ hdl/lkvc_ram.sv @@
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lkvc_controller.sv @@
module lkvc_controller import lkvc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lkvc_status_type status,
   output lkvc_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         // The last entry read is compared in this cycle.
         ST_FINISH: begin
            state_in = ST_COMMIT;
         end
         // Hold here while the previous result word is still unclaimed.
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/lkvc_datapath.sv @@
module lkvc_datapath import lkvc_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  lkvc_cmd_type       cmd,
   output lkvc_status_type    status,
   input  logic               req_opcode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_read_value,
   output logic               rsp_evicted,
   output logic [KEY_W-1:0]   rsp_evicted_key
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // Request held for the whole scan.
   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] val_ff;

   // Scan pointer, and the compare stage registered behind it.
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             cmp_pend_ff;
   logic [IDX_W-1:0] cmp_idx_ff;

   // What the scan found.
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   hit_rank_ff, hit_rank_in;
   logic [VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic               vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]   vic_slot_ff, vic_slot_in;
   logic [KEY_W-1:0]   vic_key_ff, vic_key_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;

   // Directory state.
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]    rank_ff [CAPACITY];
   logic [IDX_W-1:0]    rank_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff, count_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic               rsp_ev_ff, rsp_ev_in;
   logic [KEY_W-1:0]   rsp_evkey_ff, rsp_evkey_in;

   logic [KEY_W-1:0]    key_rd;
   logic [VALUE_W-1:0]  val_rd;
   logic [CAPACITY-1:0] lru_vec;
   logic                full;
   logic                insert;
   logic                do_update;
   logic [IDX_W-1:0]    commit_slot;
   logic [IDX_W-1:0]    old_rank;
   logic                key_we;
   logic                val_we;

   lkvc_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (commit_slot),
      .wr_data (key_ff),
      .rd_en   (cmd.scan),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd)
   );

   lkvc_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (commit_slot),
      .wr_data (val_ff),
      .rd_en   (cmd.scan),
      .rd_addr (scan_idx_ff),
      .rd_data (val_rd)
   );

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lru_vec[i] = valid_ff[i] && (rank_ff[i] == LAST_IDX);
      end
   end

   assign full        = (count_ff == FULL_CNT);
   assign insert      = !found_ff && (op_ff == OP_SET);
   assign do_update   = found_ff || (op_ff == OP_SET);
   assign commit_slot = found_ff ? slot_ff : (full ? vic_slot_ff : free_slot_ff);
   assign old_rank    = found_ff ? hit_rank_ff : (full ? LAST_IDX : IDX_W'(count_ff));
   assign key_we      = cmd.commit && insert;
   assign val_we      = cmd.commit && (op_ff == OP_SET);

   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_val_in    = hit_val_ff;
      vic_found_in  = vic_found_ff;
      vic_slot_in   = vic_slot_ff;
      vic_key_in    = vic_key_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evkey_in  = rsp_evkey_ff;

      if (cmd.start) begin
         scan_idx_in   = '0;
         found_in      = 1'b0;
         vic_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      // Compare the entry that was read in the previous cycle; first match wins.
      if (cmp_pend_ff) begin
         if (valid_ff[cmp_idx_ff] && (key_rd == key_ff) && !found_ff) begin
            found_in    = 1'b1;
            slot_in     = cmp_idx_ff;
            hit_rank_in = rank_ff[cmp_idx_ff];
            hit_val_in  = val_rd;
         end
         if (lru_vec[cmp_idx_ff] && !vic_found_ff) begin
            vic_found_in = 1'b1;
            vic_slot_in  = cmp_idx_ff;
            vic_key_in   = key_rd;
         end
         if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = cmp_idx_ff;
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = found_ff;
         rsp_ev_in    = insert && full;
         rsp_evkey_in = (insert && full) ? vic_key_ff : '0;
         if (op_ff == OP_SET) begin
            rsp_rd_in = '0;
         end else if (found_ff) begin
            rsp_rd_in = hit_val_ff;
         end else begin
            rsp_rd_in = MISS_VALUE;
         end

         // Promote the touched entry: everything more recent than it ages by one.
         if (do_update) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (IDX_W'(i) == commit_slot) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < old_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end
         if (insert) begin
            valid_in[commit_slot] = 1'b1;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         cmp_pend_ff   <= 1'b0;
         found_ff      <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         scan_idx_ff   <= scan_idx_in;
         cmp_pend_ff   <= cmd.scan;
         found_ff      <= found_in;
         vic_found_ff  <= vic_found_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rank_ff       <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      cmp_idx_ff   <= scan_idx_ff;
      slot_ff      <= slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      vic_slot_ff  <= vic_slot_in;
      vic_key_ff   <= vic_key_in;
      free_slot_ff <= free_slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evkey_ff <= rsp_evkey_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

@@ hdl/lru_key_value_cache_top.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// The req channel carries one request word: an opcode (get or set), a key and,
// for a set, the value to store. The rsp channel returns one result word per
// request: whether the key was present, the value read (all ones on a get
// miss, zero for a set), and whether a set evicted the least recent entry,
// together with the evicted key.
// Keys and values live in two small RAMs of CAPACITY entries with registered
// reads; valid bits and recency ranks sit in flip-flops. Each request scans
// the RAMs one entry per cycle, then compares the last entry read and then
// updates the stores and loads the result register. The next request word
// is accepted only after that update, one request at a time, since the scan
// walks through the single read port of the key RAM.
// A new request is accepted while a previous result word still waits in the
// output register; if the receiver stalls, the following request finishes its
// scan and then holds before its update until the waiting word is taken.
// Synchronous reset clears all valid bits, ranks and the entry count, so the
// cache comes up empty, and drops any pending result word. No clearing pass
// of the RAMs is needed.
module lru_key_value_cache_top import lkvc_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   lkvc_req_if.sink   req,
   lkvc_rsp_if.source rsp
);

   lkvc_cmd_type    cmd;
   lkvc_status_type status;

   // The controller sequences accept, scan, final compare and update.
   lkvc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stores, the scan registers and the result word.
   lkvc_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req.opcode),
      .req_key         (req.lookup_key),
      .req_value       (req.write_value),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_hit         (rsp.hit),
      .rsp_read_value  (rsp.read_value),
      .rsp_evicted     (rsp.evicted),
      .rsp_evicted_key (rsp.evicted_key)
   );

endmodule

@@ hdl/lkvc_checker.sv @@
module lkvc_checker import lkvc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [VALUE_W-1:0] rsp_read_value,
   input logic               rsp_evicted,
   input logic [KEY_W-1:0]   rsp_evicted_key
);

   // A waiting result word stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_read_value) && $stable(rsp_evicted) && $stable(rsp_evicted_key))
      else $error("result word changed while stalled");

   // Only a set that missed can evict, and a set always reads as zero.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_read_value == '0))
      else $error("eviction reported on a hit or with a nonzero read value");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> (rsp_evicted_key == '0))
      else $error("evicted key nonzero without an eviction");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A result word appears no sooner than the cycle after an update.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result word appeared right after an accept");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_hit         (rsp.hit),
   .rsp_read_value  (rsp.read_value),
   .rsp_evicted     (rsp.evicted),
   .rsp_evicted_key (rsp.evicted_key)
);

@@ sim/lru_key_value_cache_top_test.sv @@
`timescale 1ns / 1ps

module lru_key_value_cache_top_test;
   import lkvc_pkg::*;

   localparam int CACHE_DEPTH = DEFAULT_CAPACITY;
   // Time the bench allows the block to answer after it takes a request word.
   localparam int ACCESS_LATENCY = CACHE_DEPTH + 2;
   // Longest stretch the receiver refuses words during the back-pressure test.
   localparam int HOLD_CYCLES = 150;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int KEY_POOL_SIZE = 6;

   // One expected result word, with the fields in the order of the rsp channel.
   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
      logic [KEY_W-1:0]   evicted_key;
   } cache_result_type;

   logic clock;
   logic reset;

   lkvc_req_if req_ch ();
   lkvc_rsp_if rsp_ch ();

   lru_key_value_cache_top #(
      .CAPACITY(CACHE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   // Shadow copy of the cache contents, updated when a request word is accepted.
   logic [KEY_W-1:0]   shadow_key [CACHE_DEPTH];
   logic [VALUE_W-1:0] shadow_value [CACHE_DEPTH];
   logic               shadow_valid [CACHE_DEPTH];
   logic [1:0]         shadow_rank [CACHE_DEPTH];
   logic [2:0]         shadow_count;

   // Results still owed by the block, oldest first.
   cache_result_type pending_results[$];

   logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

   int error_count = 0;
   int idle_cycles = 0;

   // Idle controls: each side may insert a random gap before every word.
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   // Set by the test to make the receiver refuse words for a stretch set by HOLD_CYCLES.
   bit hold_off_req = 1'b0;

   // 10 ns clock period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Move entry s to the front. Every valid entry that was more recent than
   // the given rank ages by one place.
   function automatic void make_most_recent(int s, logic [2:0] old_rank);
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (shadow_valid[i] && i != s && {1'b0, shadow_rank[i]} < old_rank) begin
            shadow_rank[i] = shadow_rank[i] + 2'd1;
         end
      end
      shadow_rank[s] = 2'd0;
   endfunction

   // Apply one request to the shadow cache and return the result word it owes.
   function automatic cache_result_type predict_access(logic op, logic [KEY_W-1:0] key,
                                                       logic [VALUE_W-1:0] value);
      cache_result_type res;
      int slot;
      bit found;
      res = '0;
      slot = 0;
      found = 1'b0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (!found && shadow_valid[i] && shadow_key[i] == key) begin
            slot = i;
            found = 1'b1;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         if (op == OP_GET) begin
            res.read_value = shadow_value[slot];
         end else begin
            shadow_value[slot] = value;
         end
         make_most_recent(slot, {1'b0, shadow_rank[slot]});
      end else if (op == OP_GET) begin
         res.read_value = MISS_VALUE;
      end else if (shadow_count >= CACHE_DEPTH) begin
         // Full cache: the least recent entry is replaced where it sits.
         found = 1'b0;
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (!found && shadow_valid[i] && shadow_rank[i] == 2'(CACHE_DEPTH - 1)) begin
               slot = i;
               found = 1'b1;
            end
         end
         res.evicted = 1'b1;
         res.evicted_key = shadow_key[slot];
         shadow_key[slot] = key;
         shadow_value[slot] = value;
         shadow_valid[slot] = 1'b1;
         make_most_recent(slot, 3'(CACHE_DEPTH - 1));
      end else begin
         // Room left: the lowest-numbered empty entry is filled.
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (!found && !shadow_valid[i]) begin
               slot = i;
               found = 1'b1;
            end
         end
         shadow_key[slot] = key;
         shadow_value[slot] = value;
         shadow_valid[slot] = 1'b1;
         make_most_recent(slot, shadow_count);
         shadow_count = shadow_count + 3'd1;
      end
      return res;
   endfunction

   // Drive one request word at a falling edge, after an optional gap, and
   // hold it until the block takes it. The word is predicted on acceptance.
   task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.lookup_key  <= key;
      req_ch.write_value <= value;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      pending_results.push_back(predict_access(op, key, value));
   endtask

   // Stop offering words until every owed result has come back, then give
   // the block its latency once more so that it is fully idle.
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (ACCESS_LATENCY) @(posedge clock);
   endtask

   // Keys are drawn mostly from a small pool larger than the cache, so that
   // hits, updates and evictions all happen often. The rest are the extremes
   // of the key range or fully random patterns.
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      end else if (r < 82) begin
         case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return $urandom;
   endfunction

   function automatic void refresh_key_pool();
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
   endfunction

   // A get on an empty cache misses and must return all ones.
   task automatic test_empty_lookup();
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
   endtask

   // Fill every entry with the extreme keys and values, then read them back.
   // A stored value of all ones must still come back as a hit.
   task automatic test_fill_and_read();
      send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // A set on a present key overwrites in place without eviction. The value
   // that comes with a get must be ignored.
   task automatic test_overwrite();
      send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
   endtask

   // New keys into a full cache evict the least recent entry. Reading an
   // entry protects it, so the next eviction must pick a different one.
   task automatic test_eviction_order();
      send_request(OP_SET, 32'h0000_0001, 32'h0000_0011);
      send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(OP_SET, 32'h0000_0002, 32'h0000_0022);
      send_request(OP_SET, 32'h0000_0003, 32'h0000_0033);
      send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_request(OP_SET, 32'h0000_0004, 32'h0000_0044);
      send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Random mix of gets and sets; the key pool is renewed every so often so
   // that the cache keeps seeing fresh keys as well as repeated ones.
   task automatic test_random_traffic(int count, bit req_idle, bit rsp_idle);
      req_idle_on = req_idle;
      rsp_idle_on = rsp_idle;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            refresh_key_pool();
         end
         send_request($urandom_range(0, 1) ? OP_SET : OP_GET, pick_key(), pick_value());
      end
   endtask

   // The receiver refuses words for a long stretch while requests keep
   // coming, so the block fills up and must stall its input.
   task automatic test_output_stall();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_off_req = 1'b1;
      for (int n = 0; n < 40; n++) begin
         send_request($urandom_range(0, 1) ? OP_SET : OP_GET, pick_key(), pick_value());
      end
   endtask

   // Receiver side: a random gap before each word when idling is on,
   // or a long refusal when the test asks for one.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         gap = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Every accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      cache_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ns: result word expected none actual hit=%b read=%h ev=%b key=%h",
                     $time, rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted,
                     rsp_ch.evicted_key);
         end else begin
            want = pending_results.pop_front();
            report_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
            report_field("read_value", want.read_value, rsp_ch.read_value);
            report_field("evicted", 32'(want.evicted), 32'(rsp_ch.evicted));
            report_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
         end
      end
   end

   // Watchdog: the run is hung if no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("lru_key_value_cache_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         shadow_key[i] = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = '0;
      end
      shadow_count = '0;
      refresh_key_pool();
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_GET;
      req_ch.lookup_key = '0;
      req_ch.write_value = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with both sides idling at random.
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_empty_lookup();
      test_fill_and_read();
      test_overwrite();
      test_eviction_order();
      wait_for_drain();

      // Random part: gaps on both sides, a long output stall, then gaps on each side alone, then none.
      test_random_traffic(900, 1'b1, 1'b1);
      wait_for_drain();
      test_output_stall();
      wait_for_drain();
      test_random_traffic(250, 1'b0, 1'b1);
      test_random_traffic(250, 1'b1, 1'b0);
      test_random_traffic(300, 1'b0, 1'b0);
      wait_for_drain();

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("lru_key_value_cache_top: match");
      end else begin
         $display("lru_key_value_cache_top: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/lkvc_pkg.sv
hdl/lkvc_if.sv
hdl/lkvc_ram.sv
hdl/lkvc_controller.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache_top.sv
hdl/lkvc_checker.sv
sim/lru_key_value_cache_top_test.sv
